// ----- sv/glm_minibatch_gradient_assert.svh -----
// Assertion macros for the GLM mini-batch gradient block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef GLM_MINIBATCH_GRADIENT_ASSERT_SVH
`define GLM_MINIBATCH_GRADIENT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GLMMG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GLMMG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/glmmg_pkg.sv -----
// Package for the GLM mini-batch gradient block: codes, chain types,
// saturation helper and the sigmoid table. No dependencies.
`timescale 1ns / 1ps

package glmmg_pkg;

   // Width of the gradient and dot-product accumulators.
   localparam int ACC_W = 56;

   typedef enum logic [1:0] {
      CMD_COEF    = 2'd0,
      CMD_LABEL   = 2'd1,
      CMD_FEATURE = 2'd2,
      CMD_END     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_SAT   = 2'd2
   } status_type;

   // Register indexes on the configuration port.
   typedef enum logic {
      REG_MODE   = 1'b0,
      REG_FCOUNT = 1'b1
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DOT,
      S_RES,
      S_PASS,
      S_DLOAD,
      S_DWAIT,
      S_ZERO
   } state_type;

   // Residual token that walks down the cell chain at row end.
   typedef struct packed {
      logic               valid;
      logic signed [32:0] r;
   } cell_tok_type;

   // Controls broadcast to every cell.
   typedef struct packed {
      logic               buf_we;
      logic [3:0]         buf_idx;
      logic signed [31:0] buf_data;
      logic               shift;
      logic               clear;
      logic [4:0]         nf;
   } cell_bcast_type;

   typedef logic [15:0] sig_rom_type [256];

   localparam logic [31:0] EXP_STEP = 32'd4034748382;

   // Saturate a wide sum to the signed accumulator range.
   function automatic logic signed [ACC_W-1:0] sat56(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sd36028797018963967;
      lo = -66'sd36028797018963968;
      if (v > hi) return hi[ACC_W-1:0];
      if (v < lo) return lo[ACC_W-1:0];
      return v[ACC_W-1:0];
   endfunction

   // Sigmoid over [-8,8) in steps of 1/16, Q0.16, rounded to nearest.
   // Built from e^(-m/16) in Q0.32 with a restoring long division.
   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      logic [63:0] e [129];
      logic [95:0] p;
      logic [63:0] ev;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] n;
      logic [63:0] q;
      logic [63:0] rem;
      e[0] = 64'd1 << 32;
      for (int k = 1; k <= 128; k++) begin
         p = {32'b0, e[k-1]} * {64'b0, EXP_STEP} + (96'd1 << 31);
         e[k] = p[95:32];
      end
      for (int k = 0; k < 256; k++) begin
         ev  = (k < 128) ? e[128-k] : e[k-128];
         den = (64'd1 << 32) + ev;
         num = (k < 128) ? (ev << 16) : (64'd1 << 48);
         n   = num + (den >> 1);
         q   = '0;
         rem = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= den) begin
               rem  = rem - den;
               q[b] = 1'b1;
            end
         end
         rom[k] = q[15:0];
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

endpackage

// ----- sv/glmmg_cell.sv -----
// One lane of the gradient chain: buffered feature, accumulator, residual pass.
// Depends on glmmg_pkg.
`timescale 1ns / 1ps

module glmmg_cell
   import glmmg_pkg::*;
#(
   parameter int LANE      = 0,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_bcast_type           bcast,
   input  cell_tok_type             tok_in,
   output cell_tok_type             tok_out,
   input  logic signed [ACC_W-1:0]  sum_in,
   output logic signed [ACC_W-1:0]  sum_out
);

   logic signed [31:0]      buf_ff;
   logic signed [ACC_W-1:0] sum_ff;
   logic signed [ACC_W-1:0] sum_in_nxt;
   logic signed [64:0]      prod_ff;
   logic signed [64:0]      prod_in;
   logic                    pend_ff;
   logic                    active;
   cell_tok_type            tok_ff;

   assign active  = (5'(LANE) < bcast.nf);
   assign prod_in = tok_in.r * buf_ff;

   // Floor-shifted product added into the saturating accumulator.
   assign sum_in_nxt = sat56(66'(sum_ff) + 66'(prod_ff >>> FRAC_BITS));

   // Feature buffer; its reset value is never read.
   always_ff @(posedge clock) begin
      if (bcast.buf_we && (bcast.buf_idx == 4'(LANE))) begin
         buf_ff <= bcast.buf_data;
      end
   end

   // Token stage and product register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         tok_ff  <= tok_in;
         pend_ff <= tok_in.valid && active;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Accumulator: clear, shift toward the head, or add the product.
   always_ff @(posedge clock) begin
      if (reset || bcast.clear) begin
         sum_ff <= '0;
      end else if (bcast.shift) begin
         sum_ff <= sum_in;
      end else if (pend_ff) begin
         sum_ff <= sum_in_nxt;
      end
   end

   assign tok_out = tok_ff;
   assign sum_out = sum_ff;

endmodule

// ----- sv/glmmg_div.sv -----
// Restoring divider, one quotient bit per cycle, with Q16.16 saturation.
// Depends on glmmg_pkg.
`timescale 1ns / 1ps

module glmmg_div
   import glmmg_pkg::*;
#(
   parameter int CW = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] dividend,
   input  logic [CW-1:0]           divisor,
   output logic                    done,
   output logic signed [31:0]      quot,
   output logic                    sat
);

   localparam int NW = $clog2(ACC_W);

   logic [ACC_W-1:0] q_ff;
   logic [CW-1:0]    rem_ff;
   logic [NW-1:0]    cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic             neg_ff;
   logic [CW:0]      trial;
   logic             fits;
   logic             big;
   logic [31:0]      mag;

   assign trial = {rem_ff, q_ff[ACC_W-1]};
   assign fits  = (trial >= {1'b0, divisor});

   // Iterate over the dividend magnitude, most significant bit first.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == NW'(ACC_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[ACC_W-1];
         q_ff   <= dividend[ACC_W-1] ? (ACC_W)'(-dividend) : dividend;
         rem_ff <= '0;
      end else if (run_ff) begin
         q_ff   <= {q_ff[ACC_W-2:0], fits};
         rem_ff <= fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
      end
   end

   // Truncation toward zero, then clamp to the 32-bit range.
   assign mag = q_ff[31:0];
   always_comb begin
      if (neg_ff) begin
         big = (|q_ff[ACC_W-1:32]) || (q_ff[31] && (|q_ff[30:0]));
         quot = big ? 32'sh8000_0000 : -$signed(mag);
      end else begin
         big = |q_ff[ACC_W-1:31];
         quot = big ? 32'sh7FFF_FFFF : $signed(mag);
      end
   end

   assign sat  = big;
   assign done = done_ff;

endmodule

// ----- sv/glm_minibatch_gradient.sv -----
// Top level of the GLM mini-batch gradient block: command decode, dot product,
// prediction, cell chain and batch-end division. Depends on glmmg_pkg,
// glmmg_cell, glmmg_div and glm_minibatch_gradient_assert.svh.
//
//   Channel   Ports                                 Handshake
//   request   req_cmd, req_feature_index, req_value start / busy
//   result    rsp_grad_index, rsp_grad_value,       rsp_valid strobe
//             rsp_last_flag, rsp_status
//   config    psel, penable, pwrite, paddr, pwdata  APB, pready tied high
//
// A coefficient or label beat is taken in the idle state; a feature beat also passes
// through the dot state. A feature that completes a row adds the residual state and,
// if the batch has room, the pass state while the residual walks down the cell chain.
// End of batch loads and waits on the one-bit-per-cycle divider for each gradient
// element; an empty batch emits one element per cycle.
// Reset is synchronous; results are strobed once and cannot be stalled.
`timescale 1ns / 1ps
`include "glm_minibatch_gradient_assert.svh"

module glm_minibatch_gradient
   import glmmg_pkg::*;
#(
   parameter int FEATURES  = 16,
   parameter int MAX_BATCH = 65535,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_feature_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [3:0]         rsp_grad_index,
   output logic signed [31:0] rsp_grad_value,
   output logic               rsp_last_flag,
   output logic [1:0]         rsp_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int LANES = (FEATURES < 16) ? FEATURES : 16;
   localparam int IW    = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int CW    = $clog2(MAX_BATCH + 1);
   localparam int PCW   = $clog2(LANES + 1);
   localparam int SL    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SR    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

   state_type state_ff, state_in;

   logic                    mode_ff;
   logic [4:0]              fcount_ff;
   logic signed [31:0]      coef_ff [LANES];
   logic signed [ACC_W-1:0] dot_ff;
   logic signed [ACC_W-1:0] dot_in;
   logic signed [63:0]      prod_ff;
   logic signed [31:0]      label_ff;
   logic [CW-1:0]           rows_ff;
   logic [4:0]              seen_ff;
   logic [4:0]              seen_in;
   logic signed [32:0]      r_ff;
   logic                    tok_vld_ff;
   logic [PCW-1:0]          pass_ff;
   logic [4:0]              oidx_ff;
   logic                    rsp_valid_ff;
   logic [3:0]              rsp_index_ff;
   logic signed [31:0]      rsp_value_ff;
   logic                    rsp_last_ff;
   status_type              rsp_status_ff;

   logic [4:0]              nf;
   logic                    acc;
   cmd_type                 cmd;
   logic                    idx_ok;
   logic                    last_elem;
   logic                    room;
   logic signed [31:0]      eta;
   logic signed [ACC_W-1:0] ksh;
   logic signed [ACC_W:0]   kk;
   logic [7:0]              kidx;
   logic [31:0]             sig_q;
   logic                    div_start;
   logic                    div_done;
   logic signed [31:0]      div_quot;
   logic                    div_sat;
   cell_bcast_type          bcast;
   cell_tok_type            tok_chain [LANES+1];
   logic signed [ACC_W-1:0] sum_chain [LANES];
   logic                    csr_wr;

   // Effective feature count, clamped to 1..LANES.
   always_comb begin
      if (fcount_ff == 5'd0) begin
         nf = 5'd1;
      end else if (fcount_ff > 5'(LANES)) begin
         nf = 5'(LANES);
      end else begin
         nf = fcount_ff;
      end
   end

   assign acc       = start && !busy;
   assign cmd       = cmd_type'(req_cmd);
   assign idx_ok    = ({1'b0, req_feature_index} < nf);
   assign last_elem = (oidx_ff == nf - 5'd1);
   assign room      = (rows_ff < CW'(MAX_BATCH));
   assign seen_in   = seen_ff + 5'd1;

   // Dot accumulation of the registered product.
   assign dot_in = sat56(66'(dot_ff) + 66'(prod_ff >>> FRAC_BITS));

   // Prediction: saturated dot product, or the table sigmoid.
   assign ksh = dot_ff >>> (FRAC_BITS - 4);
   assign kk  = (ACC_W+1)'(ksh) + (ACC_W+1)'(128);
   always_comb begin
      if (kk < 0) begin
         kidx = 8'd0;
      end else if (kk > (ACC_W+1)'(255)) begin
         kidx = 8'd255;
      end else begin
         kidx = kk[7:0];
      end
   end
   assign sig_q = ({16'b0, SIG_ROM[kidx]} << SL) >> SR;

   always_comb begin
      if (mode_ff) begin
         eta = $signed(sig_q);
      end else if (dot_ff > 56'sd2147483647) begin
         eta = 32'sh7FFF_FFFF;
      end else if (dot_ff < -56'sd2147483648) begin
         eta = 32'sh8000_0000;
      end else begin
         eta = dot_ff[31:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (cmd == CMD_FEATURE && idx_ok) begin
                  state_in = S_DOT;
               end else if (cmd == CMD_END) begin
                  state_in = (rows_ff == '0) ? S_ZERO : S_DLOAD;
               end
            end
         end
         S_DOT:   state_in = (seen_in >= nf) ? S_RES : S_IDLE;
         S_RES:   state_in = room ? S_PASS : S_IDLE;
         S_PASS:  state_in = (pass_ff == PCW'(LANES)) ? S_IDLE : S_PASS;
         S_DLOAD: state_in = S_DWAIT;
         S_DWAIT: begin
            if (div_done) begin
               state_in = last_elem ? S_IDLE : S_DLOAD;
            end
         end
         S_ZERO:  state_in = last_elem ? S_IDLE : S_ZERO;
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      busy           = (state_ff != S_IDLE);
      div_start      = (state_ff == S_DLOAD);
      bcast.buf_we   = acc && (cmd == CMD_FEATURE) && idx_ok;
      bcast.buf_idx  = req_feature_index;
      bcast.buf_data = req_value;
      bcast.shift    = (state_ff == S_DWAIT) && div_done;
      bcast.clear    = ((state_ff == S_DWAIT) && div_done && last_elem) ||
                       ((state_ff == S_ZERO) && last_elem);
      bcast.nf       = nf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   assign csr_wr = psel && penable && pwrite && pready;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b1;
         fcount_ff <= 5'd16;
      end else if (csr_wr) begin
         if (reg_type'(paddr[2]) == REG_MODE) begin
            mode_ff <= pwdata[0];
         end else begin
            fcount_ff <= pwdata[4:0];
         end
      end
   end
   assign prdata = (reg_type'(paddr[2]) == REG_MODE) ? {31'b0, mode_ff} : {27'b0, fcount_ff};
   assign pready = 1'b1;

   // Coefficient table.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (acc && cmd == CMD_COEF && ({1'b0, req_feature_index} < 5'(LANES))) begin
         coef_ff[req_feature_index[IW-1:0]] <= req_value;
      end
   end

   // Product of coefficient and feature, ahead of the dot accumulation.
   always_ff @(posedge clock) begin
      if (acc) begin
         prod_ff <= coef_ff[req_feature_index[IW-1:0]] * req_value;
      end
   end

   // Row and batch bookkeeping, residual launch and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff        <= '0;
         label_ff      <= '0;
         rows_ff       <= '0;
         seen_ff       <= '0;
         tok_vld_ff    <= 1'b0;
         pass_ff       <= '0;
         oidx_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         tok_vld_ff   <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (acc && (cmd == CMD_LABEL || cmd == CMD_END)) begin
                  dot_ff  <= '0;
                  seen_ff <= '0;
                  oidx_ff <= '0;
                  if (cmd == CMD_LABEL) begin
                     label_ff <= req_value;
                  end
               end
            end
            S_DOT: begin
               dot_ff  <= dot_in;
               seen_ff <= seen_in;
            end
            S_RES: begin
               dot_ff  <= '0;
               seen_ff <= '0;
               if (room) begin
                  r_ff       <= {eta[31], eta} - {label_ff[31], label_ff};
                  tok_vld_ff <= 1'b1;
                  rows_ff    <= rows_ff + 1'b1;
                  pass_ff    <= '0;
               end
            end
            S_PASS: pass_ff <= pass_ff + 1'b1;
            S_DWAIT: begin
               if (div_done) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_index_ff  <= oidx_ff[3:0];
                  rsp_value_ff  <= div_quot;
                  rsp_last_ff   <= last_elem;
                  rsp_status_ff <= div_sat ? STAT_SAT : STAT_OK;
                  oidx_ff       <= oidx_ff + 5'd1;
                  if (last_elem) begin
                     rows_ff <= '0;
                  end
               end
            end
            S_ZERO: begin
               rsp_valid_ff  <= 1'b1;
               rsp_index_ff  <= oidx_ff[3:0];
               rsp_value_ff  <= '0;
               rsp_last_ff   <= last_elem;
               rsp_status_ff <= STAT_EMPTY;
               oidx_ff       <= oidx_ff + 5'd1;
            end
            default: begin
            end
         endcase
      end
   end

   // Chain of gradient cells; the residual enters at lane 0.
   assign tok_chain[0].valid = tok_vld_ff;
   assign tok_chain[0].r     = r_ff;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic signed [ACC_W-1:0] next_sum;
      if (g == LANES - 1) begin : g_tail
         assign next_sum = '0;
      end else begin : g_body
         assign next_sum = sum_chain[g+1];
      end
      glmmg_cell #(
         .LANE      (g),
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .bcast   (bcast),
         .tok_in  (tok_chain[g]),
         .tok_out (tok_chain[g+1]),
         .sum_in  (next_sum),
         .sum_out (sum_chain[g])
      );
   end

   // Batch-end divider fed from the chain head.
   glmmg_div #(
      .CW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_chain[0]),
      .divisor  (rows_ff),
      .done     (div_done),
      .quot     (div_quot),
      .sat      (div_sat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grad_index = rsp_index_ff;
   assign rsp_grad_value = rsp_value_ff;
   assign rsp_last_flag  = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

   // Checks on the sequencer and result stream.
   `GLMMG_ASSERT_SAME(a_rsp_while_busy, rsp_valid, $past(busy), "result beat without work")
   `GLMMG_ASSERT_NEXT(a_last_ends_batch, rsp_valid && rsp_last_flag, !rsp_valid,
      "beat after last element")
   `GLMMG_ASSERT_SAME(a_empty_is_zero, rsp_valid && rsp_status == STAT_EMPTY,
      rsp_grad_value == 32'sd0, "empty batch gave nonzero value")

endmodule
